// ----- hw/rtl/cspr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cspr_pkg;

  // Command codes of the input item
  typedef enum logic [2:0] {
    CMD_ENTRY  = 3'd0,
    CMD_RETURN = 3'd1,
    CMD_SENT   = 3'd2,
    CMD_RECV   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_ALLOC  = 3'd5
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PROCESS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_WALL_NS    = 4'd1;

  localparam int PID_W  = 22;
  localparam int TIME_W = 64;
  localparam int CNT_W  = 64;

  // Start times of one frame
  typedef struct packed {
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] cpu;
  } frame_times_t;

  // Resource counters of one frame
  typedef struct packed {
    logic [CNT_W-1:0] tx;
    logic [CNT_W-1:0] rx;
    logic [CNT_W-1:0] io;
    logic [CNT_W-1:0] alloc;
  } frame_cnt_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cspr_frame_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cspr_frame_mem
  import cspr_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  // start time store: one read, one write port
  input  wire logic                     times_rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] times_rd_addr,
  output frame_times_t                  times_rd,
  input  wire logic                     times_we,
  input  wire logic [$clog2(DEPTH)-1:0] times_wr_addr,
  input  wire frame_times_t             times_wr,
  // counter store: two read ports (frame and its parent), one write port
  input  wire logic                     cnt_rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] cnt_rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] cnt_rd_addr_b,
  output frame_cnt_t                    cnt_rd_a,
  output frame_cnt_t                    cnt_rd_b,
  input  wire logic                     cnt_we,
  input  wire logic [$clog2(DEPTH)-1:0] cnt_wr_addr,
  input  wire frame_cnt_t               cnt_wr
);

  frame_times_t times_mem [DEPTH];
  frame_cnt_t   cnt_mem   [DEPTH];

  // start time store, read data held until the next read
  always_ff @(posedge clk) begin
    if (times_we) begin
      times_mem[times_wr_addr] <= times_wr;
    end
    if (times_rd_en) begin
      times_rd <= times_mem[times_rd_addr];
    end
  end

  // counter store
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr;
    end
    if (cnt_rd_en) begin
      cnt_rd_a <= cnt_mem[cnt_rd_addr_a];
      cnt_rd_b <= cnt_mem[cnt_rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/call_stack_resource_profiler.sv -----
// Channel  | Direction | Handshake           | Beat
// item     | in        | item_valid/stall    | cmd, process_id, times, amount, name_pass
// result   | out       | result_valid/stall  | wall/cpu elapsed, four byte totals
// cfg      | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// One item at a time. Items that touch no frame (other process, unknown command,
// ignored resource, entry or return beyond the stack cap) finish in S_IDLE. The frame
// store has a registered read. Pushing entries pass through S_ENTRY, resource items through
// S_RES; returns that pop a tracked frame fold counters into the parent in S_RET_SUM
// and form the result in S_RET_OUT, where they wait while a previous result is stalled.
// Reset (rst, synchronous) clears state, depth, configuration and result_valid;
// the result data and frame memories are not cleared. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module call_stack_resource_profiler
  import cspr_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // item channel
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [2:0]             cmd,
  input  wire logic [PID_W-1:0]       process_id,
  input  wire logic [TIME_W-1:0]      now_ns,
  input  wire logic [TIME_W-1:0]      run_total_ns,
  input  wire logic [TIME_W-1:0]      slice_start_ns,
  input  wire logic signed [63:0]     amount,
  input  wire logic                   name_pass,
  // result channel
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [TIME_W-1:0]           wall_elapsed_ns,
  output logic [TIME_W-1:0]           cpu_elapsed_ns,
  output logic [CNT_W-1:0]            sent_bytes,
  output logic [CNT_W-1:0]            received_bytes,
  output logic [CNT_W-1:0]            written_bytes,
  output logic [CNT_W-1:0]            allocated_bytes,
  // configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [31:0]   DEPTH_LIM = 32'(STACK_DEPTH);
  localparam logic [AW-1:0] TOP_IDX   = AW'(STACK_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENTRY,
    S_RES,
    S_RET_SUM,
    S_RET_OUT
  } state_t;

  state_t state;

  // configuration
  logic [PID_W-1:0]  target_process;
  logic [TIME_W-1:0] min_wall_ns;

  logic [31:0] depth_count;

  // captured item
  logic [AW-1:0]     frame_addr;
  logic              has_parent;
  logic [2:0]        res_cmd;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] run_q;
  logic [TIME_W-1:0] slice_diff;
  logic              slice_later;
  logic [CNT_W-1:0]  amount_q;
  logic              name_pass_q;
  logic [TIME_W-1:0] wall_delta;
  logic [TIME_W-1:0] cpu_end;

  // memory side
  logic         times_rd_en;
  frame_times_t times_rd;
  logic         times_we;
  frame_times_t times_wr;
  logic         cnt_rd_en;
  logic [AW-1:0] rd_addr;
  frame_cnt_t   cnt_rd_a;
  frame_cnt_t   cnt_rd_b;
  logic         cnt_we;
  logic [AW-1:0] cnt_wr_addr;
  frame_cnt_t   cnt_wr;

  // item decode
  logic              accept;
  logic              hit;
  logic [31:0]       depth_m1;
  logic              depth_zero;
  logic              amount_pos;
  logic              is_res;
  logic              ret_go;
  logic              res_go;
  logic [TIME_W-1:0] cpu_now;
  logic [TIME_W-1:0] cpu_raw;
  logic [TIME_W-1:0] cpu_clamped;
  logic              emit;
  logic              out_free;
  logic              load_result;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign hit        = (process_id == target_process);
  assign depth_m1   = depth_count - 32'd1;
  assign depth_zero = (depth_count == '0);
  assign amount_pos = !amount[63] && (amount != '0);
  assign is_res     = (cmd == CMD_SENT) || (cmd == CMD_RECV) ||
                      (cmd == CMD_WRITE) || (cmd == CMD_ALLOC);
  assign ret_go     = hit && (cmd == CMD_RETURN) && !depth_zero && (depth_m1 < DEPTH_LIM);
  assign res_go     = hit && is_res && amount_pos && !depth_zero;

  // deepest tracked frame, clamped to the last entry
  assign rd_addr     = (depth_m1 >= DEPTH_LIM) ? TOP_IDX : depth_m1[AW-1:0];
  assign times_rd_en = accept && ret_go;
  assign cnt_rd_en   = accept && (ret_go || res_go);

  // CPU time at the captured item
  assign cpu_now = slice_later ? run_q + slice_diff : run_q;

  // CPU elapsed, clamped to wall elapsed
  assign cpu_raw     = (cpu_end > times_rd.cpu) ? cpu_end - times_rd.cpu : '0;
  assign cpu_clamped = (cpu_raw > wall_delta) ? wall_delta : cpu_raw;
  assign emit        = name_pass_q && (wall_delta >= min_wall_ns);
  assign out_free    = !result_valid || !result_stall;
  assign load_result = (state == S_RET_OUT) && emit && out_free;

  // memory write side
  always_comb begin
    times_we    = 1'b0;
    times_wr    = '{wall: now_q, cpu: cpu_now};
    cnt_we      = 1'b0;
    cnt_wr_addr = frame_addr;
    cnt_wr      = cnt_rd_a;
    unique case (state)
      S_ENTRY: begin
        times_we = 1'b1;
        cnt_we   = 1'b1;
        cnt_wr   = '0;
      end
      S_RES: begin
        cnt_we = 1'b1;
        unique case (res_cmd)
          CMD_SENT:  cnt_wr.tx    = cnt_rd_a.tx + amount_q;
          CMD_RECV:  cnt_wr.rx    = cnt_rd_a.rx + amount_q;
          CMD_WRITE: cnt_wr.io    = cnt_rd_a.io + amount_q;
          CMD_ALLOC: cnt_wr.alloc = cnt_rd_a.alloc + amount_q;
          default:   cnt_we       = 1'b0;
        endcase
      end
      S_RET_SUM: begin
        // fold the child's totals into its parent
        cnt_we       = has_parent;
        cnt_wr_addr  = frame_addr - AW'(1);
        cnt_wr.tx    = cnt_rd_b.tx + cnt_rd_a.tx;
        cnt_wr.rx    = cnt_rd_b.rx + cnt_rd_a.rx;
        cnt_wr.io    = cnt_rd_b.io + cnt_rd_a.io;
        cnt_wr.alloc = cnt_rd_b.alloc + cnt_rd_a.alloc;
      end
      S_IDLE, S_RET_OUT: begin
      end
      default: begin
      end
    endcase
  end

  cspr_frame_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_frame_mem (
    .clk           (clk),
    .times_rd_en   (times_rd_en),
    .times_rd_addr (rd_addr),
    .times_rd      (times_rd),
    .times_we      (times_we),
    .times_wr_addr (frame_addr),
    .times_wr      (times_wr),
    .cnt_rd_en     (cnt_rd_en),
    .cnt_rd_addr_a (rd_addr),
    .cnt_rd_addr_b (rd_addr - AW'(1)),
    .cnt_rd_a      (cnt_rd_a),
    .cnt_rd_b      (cnt_rd_b),
    .cnt_we        (cnt_we),
    .cnt_wr_addr   (cnt_wr_addr),
    .cnt_wr        (cnt_wr)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_process <= '0;
      min_wall_ns    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TARGET_PROCESS) begin
        target_process <= cfg_data[PID_W-1:0];
      end else if (cfg_index == REG_MIN_WALL_NS) begin
        min_wall_ns <= cfg_data;
      end
    end
  end

  // sequencer, depth count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      depth_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new beat may replace one leaving in the same cycle
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_q       <= now_ns;
            run_q       <= run_total_ns;
            slice_diff  <= now_ns - slice_start_ns;
            slice_later <= (now_ns > slice_start_ns);
            amount_q    <= amount;
            name_pass_q <= name_pass;
            res_cmd     <= cmd;
            if (hit && (cmd == CMD_ENTRY)) begin
              if (depth_count != '1) begin
                depth_count <= depth_count + 32'd1;
              end
              if (depth_count < DEPTH_LIM) begin
                frame_addr <= depth_count[AW-1:0];
                state      <= S_ENTRY;
              end
            end else if (hit && (cmd == CMD_RETURN) && !depth_zero) begin
              depth_count <= depth_m1;
              if (ret_go) begin
                frame_addr <= rd_addr;
                has_parent <= (depth_m1 != '0);
                state      <= S_RET_SUM;
              end
            end else if (res_go) begin
              frame_addr <= rd_addr;
              state      <= S_RES;
            end
          end
        end
        S_ENTRY, S_RES: begin
          state <= S_IDLE;
        end
        S_RET_SUM: begin
          wall_delta <= (now_q > times_rd.wall) ? now_q - times_rd.wall : '0;
          cpu_end    <= cpu_now;
          state      <= S_RET_OUT;
        end
        S_RET_OUT: begin
          if (!emit) begin
            state <= S_IDLE;
          end else if (out_free) begin
            wall_elapsed_ns <= wall_delta;
            cpu_elapsed_ns  <= cpu_clamped;
            sent_bytes      <= cnt_rd_a.tx;
            received_bytes  <= cnt_rd_a.rx;
            written_bytes   <= cnt_rd_a.io;
            allocated_bytes <= cnt_rd_a.alloc;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cspr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cspr_checker
  import cspr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic [TIME_W-1:0] wall_elapsed_ns,
  input wire logic [TIME_W-1:0] cpu_elapsed_ns
);

  // CPU time never exceeds wall time in a result
  a_cpu_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (cpu_elapsed_ns <= wall_elapsed_ns))
    else $error("cpu_elapsed_ns above wall_elapsed_ns");

  // a new result only appears while an item is in progress
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared with no item in progress");

  // no result in the cycle straight after an item beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !$rose(result_valid))
    else $error("result rose one cycle after an item beat");

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(wall_elapsed_ns) && $stable(cpu_elapsed_ns)))
    else $error("stalled result beat changed");

endmodule

bind call_stack_resource_profiler cspr_checker u_cspr_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .wall_elapsed_ns (wall_elapsed_ns),
  .cpu_elapsed_ns  (cpu_elapsed_ns)
);

`default_nettype wire
